[src/lru_resident_page_tracker_unit_assert.svh]
// ----------------------------------------------------------------------------
// LRU resident page tracker assertion macros
// Shared assertion forms for the checker of the page tracker.
// ----------------------------------------------------------------------------
`ifndef LRU_RESIDENT_PAGE_TRACKER_UNIT_ASSERT_SVH
`define LRU_RESIDENT_PAGE_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrpt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrpt assertion failed");

`endif

[src/lrpt_pkg.sv]
// ----------------------------------------------------------------------------
// LRU resident page tracker package
// Field widths, default parameters and the control bundle of the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package lrpt_pkg;

	// Widths of the fields on the ports.
	localparam int LRPT_PAGE_W  = 16;
	localparam int LRPT_COUNT_W = 5;
	localparam int LRPT_CFG_W   = 5;

	// Reset value of the resident limit register.
	localparam logic [LRPT_CFG_W-1:0] LRPT_MAX_RESET = 5'd16;

	// Default build parameters.
	localparam int LRPT_CAPACITY   = 16;
	localparam int LRPT_INDEX_BITS = 16;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic load;
		logic hit;
		logic evict;
	} lrpt_ctrl_t;

endpackage

`default_nettype wire

[src/lrpt_if.sv]
// ----------------------------------------------------------------------------
// LRU resident page tracker channels
// Valid/ready interfaces for the access request and the result.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrpt_req_if;
	logic                             valid;
	logic                             ready;
	logic [lrpt_pkg::LRPT_PAGE_W-1:0] page_index;

	modport source (output valid, output page_index, input ready);
	modport sink (input valid, input page_index, output ready);
endinterface

interface lrpt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic                              evicted;
	logic [lrpt_pkg::LRPT_PAGE_W-1:0]  evicted_index;
	logic [lrpt_pkg::LRPT_COUNT_W-1:0] resident_count;

	modport source (output valid, output hit, output evicted, output evicted_index,
		output resident_count, input ready);
	modport sink (input valid, input hit, input evicted, input evicted_index,
		input resident_count, output ready);
endinterface

`default_nettype wire

[src/lrpt_cell.sv]
// ----------------------------------------------------------------------------
// LRU resident page tracker cell
// One place of the recency stack: holds an index, compares it with the
// request and takes its upper neighbor's entry when the stack shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module lrpt_cell #(
	parameter int INDEX_BITS = lrpt_pkg::LRPT_INDEX_BITS
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lrpt_pkg::lrpt_ctrl_t    ctrl,
	input  wire  [INDEX_BITS-1:0]   key,
	input  wire  [INDEX_BITS-1:0]   up_data,
	input  wire                     up_valid,
	input  wire                     next_valid,
	input  wire                     seen_in,
	output logic                    seen_out,
	input  wire  [INDEX_BITS-1:0]   tail_in,
	output logic [INDEX_BITS-1:0]   tail_out,
	output logic [INDEX_BITS-1:0]   data,
	output logic                    valid
);

	logic [INDEX_BITS-1:0] data_q;
	logic                  valid_q;
	logic                  match;
	logic                  is_last;
	logic                  shift;

	assign match    = valid_q && (data_q == key);
	assign seen_out = seen_in | match;

	// A cell below a hit keeps its entry. On an eviction the last valid cell is
	// overwritten and the empty cell below it stays empty.
	assign shift = ctrl.load && !seen_in && up_valid &&
		(ctrl.hit || !ctrl.evict || valid_q);

	assign is_last  = valid_q && !next_valid;
	assign tail_out = tail_in | (is_last ? data_q : '0);

	assign data  = data_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= up_data;
		end
	end

endmodule

`default_nettype wire

[src/lru_resident_page_tracker_unit.sv]
// ----------------------------------------------------------------------------
// LRU resident page tracker
// Most-recently-used ordering of resident pages with LRU eviction.
// ----------------------------------------------------------------------------
// Usage:
// Each request on req carries a page index. The block looks it up among the
// resident pages and sends one result on rsp: whether the access hit, whether
// the least recently used page was evicted to make room, the evicted index
// (zero when nothing was evicted) and the resident count after the access.
// The resident limit is written through cfg_wr_en/cfg_wr_data while the block
// is idle; zero acts as one and values above CAPACITY act as CAPACITY.
// The result is registered: it is valid in the cycle after the request
// is accepted. Throughput is one request per cycle while the receiver
// takes results, set by the compare and shift across the row of cells.
// When the receiver stalls, the result is held in the output register and
// req.ready falls until the result is taken.
// Reset empties the stack, clears the output valid and restores a limit of 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_resident_page_tracker_unit #(
	parameter int CAPACITY   = lrpt_pkg::LRPT_CAPACITY,
	parameter int INDEX_BITS = lrpt_pkg::LRPT_INDEX_BITS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	lrpt_req_if.sink                         req,
	lrpt_rsp_if.source                       rsp,
	input  wire                              cfg_wr_en,
	input  wire  [lrpt_pkg::LRPT_CFG_W-1:0]  cfg_wr_data
);

	// Occupancy counts up to CAPACITY; comparisons with the limit register run
	// at the wider of the two widths.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > lrpt_pkg::LRPT_CFG_W) ? CNT_W : lrpt_pkg::LRPT_CFG_W;

	logic [lrpt_pkg::LRPT_CFG_W-1:0] max_resident_q;
	logic [CNT_W-1:0]                occ_q;
	logic [CNT_W-1:0]                occ_next;
	logic [CMP_W-1:0]                limit;
	logic [CMP_W-1:0]                max_wide;

	logic [INDEX_BITS-1:0]           key;
	logic [INDEX_BITS-1:0]           cell_data [CAPACITY];
	logic                            cell_valid [CAPACITY];
	logic                            seen [CAPACITY+1];
	logic [INDEX_BITS-1:0]           tail [CAPACITY+1];

	lrpt_pkg::lrpt_ctrl_t            ctrl;
	logic                            load;
	logic                            hit;
	logic                            evict;

	logic                            rsp_valid_q;
	logic                            hit_q;
	logic                            evicted_q;
	logic [lrpt_pkg::LRPT_PAGE_W-1:0]  evicted_index_q;
	logic [lrpt_pkg::LRPT_COUNT_W-1:0] resident_count_q;

	// A new request is taken whenever the output register is free or drains.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign load      = req.valid && req.ready;

	// Only the low INDEX_BITS bits of the page index take part.
	assign key = INDEX_BITS'(req.page_index);

	// Effective limit: zero acts as one, anything above the capacity saturates.
	assign max_wide = CMP_W'(max_resident_q);
	always_comb begin
		limit = max_wide;
		if (max_wide == '0) begin
			limit = CMP_W'(1);
		end else if (max_wide > CMP_W'(CAPACITY)) begin
			limit = CMP_W'(CAPACITY);
		end
	end

	// The hit flag comes out of the end of the match chain. A miss with the
	// stack at or above its limit drops the last valid entry.
	assign hit   = seen[CAPACITY];
	assign evict = !hit && (CMP_W'(occ_q) >= limit) && (occ_q != '0);

	assign ctrl.load  = load;
	assign ctrl.hit   = hit;
	assign ctrl.evict = evict;

	always_comb begin
		occ_next = occ_q;
		if (!hit && !evict) begin
			occ_next = occ_q + CNT_W'(1);
		end
	end

	assign seen[0] = 1'b0;
	assign tail[0] = '0;

	// The row of cells. Cell 0 is the most recently used entry and always takes
	// the request's index on an accepted request.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [INDEX_BITS-1:0] up_data;
		logic                  up_valid;
		logic                  next_valid;

		if (i == 0) begin : g_top
			assign up_data  = key;
			assign up_valid = 1'b1;
		end else begin : g_inner
			assign up_data  = cell_data[i-1];
			assign up_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_bottom
			assign next_valid = 1'b0;
		end else begin : g_above
			assign next_valid = cell_valid[i+1];
		end

		lrpt_cell #(
			.INDEX_BITS(INDEX_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key       (key),
			.up_data   (up_data),
			.up_valid  (up_valid),
			.next_valid(next_valid),
			.seen_in   (seen[i]),
			.seen_out  (seen[i+1]),
			.tail_in   (tail[i]),
			.tail_out  (tail[i+1]),
			.data      (cell_data[i]),
			.valid     (cell_valid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_resident_q <= lrpt_pkg::LRPT_MAX_RESET;
		end else if (cfg_wr_en) begin
			max_resident_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				occ_q       <= occ_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The result payload is captured with the request that produced it.
	always_ff @(posedge clk) begin
		if (load) begin
			hit_q            <= hit;
			evicted_q        <= evict;
			evicted_index_q  <= evict ? lrpt_pkg::LRPT_PAGE_W'(tail[CAPACITY]) : '0;
			resident_count_q <= lrpt_pkg::LRPT_COUNT_W'(occ_next);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.hit            = hit_q;
	assign rsp.evicted        = evicted_q;
	assign rsp.evicted_index  = evicted_index_q;
	assign rsp.resident_count = resident_count_q;

endmodule

`default_nettype wire

[src/lrpt_checker.sv]
// ----------------------------------------------------------------------------
// LRU resident page tracker checker
// Port-level properties of the page tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_resident_page_tracker_unit_assert.svh"

module lrpt_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              req_valid,
	input wire                              req_ready,
	input wire                              rsp_valid,
	input wire                              rsp_ready,
	input wire                              rsp_hit,
	input wire                              rsp_evicted,
	input wire [lrpt_pkg::LRPT_PAGE_W-1:0]  rsp_evicted_index,
	input wire [lrpt_pkg::LRPT_COUNT_W-1:0] rsp_resident_count
);

	// Every accepted request shows a result at the next edge.
	`LRPT_ASSERT_NEXT(a_result_follows, clk, arst_n, req_valid && req_ready, rsp_valid)

	// A stalled result keeps its contents.
	`LRPT_ASSERT_NEXT(a_stall_holds, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_hit) && $stable(rsp_evicted) &&
		$stable(rsp_evicted_index) && $stable(rsp_resident_count))

	// A hit never evicts.
	`LRPT_ASSERT_NOW(a_hit_no_evict, clk, arst_n, rsp_valid && rsp_hit, !rsp_evicted)

	// Without an eviction the reported index is zero.
	`LRPT_ASSERT_NOW(a_idle_index_zero, clk, arst_n, rsp_valid && !rsp_evicted,
		rsp_evicted_index == '0)

endmodule

bind lru_resident_page_tracker_unit lrpt_checker u_lrpt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_hit           (rsp.hit),
	.rsp_evicted       (rsp.evicted),
	.rsp_evicted_index (rsp.evicted_index),
	.rsp_resident_count(rsp.resident_count)
);

`default_nettype wire

[tb/lrpt_recency_checker.sv]
// ----------------------------------------------------------------------------
// LRU resident page tracker checker
// Watches the request, result and limit ports, keeps its own recency stack
// and compares every result with the outcome it expects.
// ----------------------------------------------------------------------------
module lrpt_recency_checker
	import lrpt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_ready,
	input  logic [LRPT_PAGE_W-1:0]  req_page_index,
	input  logic                    rsp_valid,
	input  logic                    rsp_ready,
	input  logic                    rsp_hit,
	input  logic                    rsp_evicted,
	input  logic [LRPT_PAGE_W-1:0]  rsp_evicted_index,
	input  logic [LRPT_COUNT_W-1:0] rsp_resident_count,
	input  logic                    cfg_wr_en,
	input  logic [LRPT_CFG_W-1:0]   cfg_wr_data,
	output int                      error_count,
	output int                      pending_results,
	output int                      hit_total,
	output int                      evict_total
);

	localparam int DEPTH = LRPT_CAPACITY;
	// Mismatches past this many are still counted but no longer printed.
	localparam int REPORT_LIMIT = 100;

	typedef struct packed {
		logic                    hit;
		logic                    evicted;
		logic [LRPT_PAGE_W-1:0]  evicted_index;
		logic [LRPT_COUNT_W-1:0] resident_count;
	} page_outcome_t;

	// Entry 0 is the most recently used page; entries 0 .. resident-1 are valid.
	logic [LRPT_PAGE_W-1:0] mru_stack [DEPTH];
	int unsigned            resident;
	logic [LRPT_CFG_W-1:0]  limit_reg;
	page_outcome_t          outcome_q [$];

	function automatic int unsigned effective_limit();
		if (limit_reg == '0)
			return 1;
		if (limit_reg > DEPTH)
			return DEPTH;
		return 32'(limit_reg);
	endfunction

	function automatic page_outcome_t apply_page_access(input logic [LRPT_PAGE_W-1:0] page);
		int unsigned   pos;
		page_outcome_t res;
		pos = DEPTH;
		res = '0;
		for (int i = 0; i < resident; i++)
			if (pos == DEPTH && mru_stack[i] == page)
				pos = i;
		if (pos != DEPTH) begin
			res.hit = 1'b1;
			for (int i = pos; i > 0; i--)
				mru_stack[i] = mru_stack[i-1];
			mru_stack[0] = page;
		end else begin
			// At or above the limit a miss first drops the least recently used page.
			if (resident >= effective_limit() && resident > 0) begin
				resident--;
				res.evicted = 1'b1;
				res.evicted_index = mru_stack[resident];
				mru_stack[resident] = '0;
			end
			if (resident < DEPTH) begin
				for (int i = resident; i > 0; i--)
					mru_stack[i] = mru_stack[i-1];
				mru_stack[0] = page;
				resident++;
			end
		end
		res.resident_count = LRPT_COUNT_W'(resident);
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		page_outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				mru_stack[i] = '0;
			resident = 0;
			limit_reg = LRPT_MAX_RESET;
			outcome_q.delete();
			error_count = 0;
			pending_results = 0;
			hit_total = 0;
			evict_total = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (outcome_q.size() == 0) begin
					error_count++;
					$error("result with no request waiting for one");
				end else begin
					want = outcome_q.pop_front();
					check_field("hit", 32'(want.hit), 32'(rsp_hit));
					check_field("evicted", 32'(want.evicted), 32'(rsp_evicted));
					check_field("evicted_index", 32'(want.evicted_index),
						32'(rsp_evicted_index));
					check_field("resident_count", 32'(want.resident_count),
						32'(rsp_resident_count));
					hit_total += int'(want.hit);
					evict_total += int'(want.evicted);
				end
			end
			if (cfg_wr_en)
				limit_reg = cfg_wr_data;
			if (req_valid && req_ready)
				outcome_q.push_back(apply_page_access(req_page_index));
			pending_results = outcome_q.size();
		end
	end

endmodule

[tb/tb_lru_resident_page_tracker_unit.sv]
// ----------------------------------------------------------------------------
// LRU resident page tracker testbench
// Drives page requests and limit writes into the tracker, stalls both sides
// at random and lets a checker beside the block compare every result.
// ----------------------------------------------------------------------------
module tb_lru_resident_page_tracker_unit;
	import lrpt_pkg::*;

	// The watchdog gives up after this many cycles with no handshake at all.
	// Sender gaps and receiver stalls from gap_len() are much shorter, so a
	// correct run never comes close.
	localparam int QUIET_LIMIT  = 1000;
	localparam int PHASES       = 12;
	localparam int RANDOM_ITEMS = 1400;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [LRPT_CFG_W-1:0]  cfg_wr_data;

	int error_count;
	int pending_results;
	int hit_total;
	int evict_total;
	int sent_total = 0;
	int config_total = 0;
	int quiet_cycles = 0;

	// Idling switches, changed per phase so that some stretches run flat out.
	bit src_gaps_on = 1'b0;
	bit sink_stalls_on = 1'b0;

	// The random pages mostly come from a small window, so that the working set
	// sits near the limit and hits, misses and evictions all stay frequent.
	logic [LRPT_PAGE_W-1:0] pool_base = '0;
	int unsigned            pool_size = 1;
	logic [LRPT_PAGE_W-1:0] last_page = '0;

	lrpt_req_if req_ch();
	lrpt_rsp_if rsp_ch();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lru_resident_page_tracker_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	lrpt_recency_checker checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_ch.valid),
		.req_ready          (req_ch.ready),
		.req_page_index     (req_ch.page_index),
		.rsp_valid          (rsp_ch.valid),
		.rsp_ready          (rsp_ch.ready),
		.rsp_hit            (rsp_ch.hit),
		.rsp_evicted        (rsp_ch.evicted),
		.rsp_evicted_index  (rsp_ch.evicted_index),
		.rsp_resident_count (rsp_ch.resident_count),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.error_count        (error_count),
		.pending_results    (pending_results),
		.hit_total          (hit_total),
		.evict_total        (evict_total)
	);

	// Gap length in cycles: mostly the short range, sometimes the middle, rarely the long one.
	function automatic int unsigned gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(1, 2);
		if (roll < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// Mostly pages from the current window, some repeats of the last page (hits
	// on the top entry), a few all-zero or all-one pages and some fully random.
	function automatic logic [LRPT_PAGE_W-1:0] pick_page();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return pool_base + LRPT_PAGE_W'($urandom_range(0, pool_size - 1));
		if (roll < 80)
			return last_page;
		if (roll < 85)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		return LRPT_PAGE_W'($urandom);
	endfunction

	// Entered at a falling edge; returns at the falling edge after the request
	// was taken, with valid still high so that a following request can go out
	// back to back.
	task automatic send_page(input logic [LRPT_PAGE_W-1:0] page);
		req_ch.valid <= 1'b1;
		req_ch.page_index <= page;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		sent_total++;
		last_page = page;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// The limit may only change while the block is idle, so every expected
	// result has to be in before the write. One result per request and a
	// registered result mean a short settle time is plenty.
	task automatic write_limit(input logic [LRPT_CFG_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		config_total++;
	endtask

	// Result side: ready drops for random stretches while stalls are enabled.
	initial begin
		int unsigned hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
				hold = gap_len() - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: counts cycles in which neither channel completes a handshake.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [LRPT_CFG_W-1:0] limit_plan [PHASES];
		int unsigned           eff_limit;

		// The plan includes zero, one, the capacity and values above it, and
		// goes from a full stack of 16 straight down to a limit of zero, which
		// leaves occupancy above the limit for the misses to work against.
		limit_plan = '{5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd15,
			5'd12, 5'd6};

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.page_index = '0;
		rsp_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, at the reset limit of 16. The stack starts empty, so
		// page zero has to miss even though the empty entries also hold zero.
		send_page('0);
		// Same page again is a hit on the top entry and leaves the order alone.
		send_page('0);
		send_page('1);
		// Hit below the top moves page zero back up.
		send_page('0);
		send_page(16'h5555);
		send_page(16'hAAAA);

		// A limit above the capacity acts as the capacity: filling past 16
		// pages has to evict the least recently used one.
		write_limit(5'd31);
		for (int i = 0; i < 13; i++)
			send_page(16'h0100 + LRPT_PAGE_W'(i));

		// A limit of zero acts as one. The full stack is not trimmed by the
		// write; each miss evicts exactly one page and occupancy holds at 16.
		write_limit(5'd0);
		send_page(16'h7777);
		send_page(16'h7777);
		send_page(16'h8888);

		// Just above the capacity, with the stack still full.
		write_limit(5'd17);
		send_page(16'h1234);

		// Random part: one phase per limit setting, with a fresh page window.
		for (int phase = 0; phase < PHASES; phase++) begin
			write_limit(limit_plan[phase]);
			if (limit_plan[phase] == '0)
				eff_limit = 1;
			else if (limit_plan[phase] > LRPT_CAPACITY)
				eff_limit = LRPT_CAPACITY;
			else
				eff_limit = 32'(limit_plan[phase]);
			pool_size = eff_limit + $urandom_range(0, 6);
			pool_base = LRPT_PAGE_W'($urandom);
			src_gaps_on = (phase % 3) != 2;
			sink_stalls_on = (phase % 4) != 3;
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				send_page(pick_page());
				if (src_gaps_on && $urandom_range(0, 3) == 0)
					pause_sender(gap_len());
			end
		end

		// Let the last results drain, then allow a few more cycles so that any
		// stray extra result would still be caught by the checker.
		req_ch.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("Sent %0d page requests across %0d limit writes (0, 1, 16, 17, 31 among them).",
			sent_total, config_total);
		$display("Checked results included %0d hits and %0d evictions.", hit_total, evict_total);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/lrpt_pkg.sv
src/lrpt_if.sv
src/lrpt_cell.sv
src/lru_resident_page_tracker_unit.sv
src/lrpt_checker.sv
tb/lrpt_recency_checker.sv
tb/tb_lru_resident_page_tracker_unit.sv
